// File: rtl/core/fcpa_pkg.sv
// Package for the fixed chunk pool allocator: operation, status and register codes,
// and the fixed field widths. No dependencies.
package fcpa_pkg;

	// Fixed field widths of the channels and registers.
	localparam int DATA_W     = 32;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int LIVE_OUT_W = 9;
	localparam int CHUNK_W    = 16;
	localparam int ALIGN_W    = 3;
	localparam int PAD_W      = 8;
	// A 16-bit chunk size rounded up to an alignment of at most 128 needs 17 bits.
	localparam int STRIDE_W   = 17;
	localparam int CFG_IDX_W  = 2;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADCFG   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2  = 2'd3;

endpackage

// File: rtl/core/fcpa_if.sv
// Valid/ready channel interfaces for the allocator: command beats in, result beats out.
// Depends on fcpa_pkg.
interface fcpa_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [fcpa_pkg::MODE_W-1:0]  mode;
	logic [fcpa_pkg::DATA_W-1:0]  address;

	modport source (output valid, mode, address, input ready);
	modport sink   (input valid, mode, address, output ready);
endinterface

interface fcpa_res_if;
	logic                           valid;
	logic                           ready;
	logic [fcpa_pkg::DATA_W-1:0]    result_address;
	logic [fcpa_pkg::STATUS_W-1:0]  status;
	logic [fcpa_pkg::DATA_W-1:0]    used_total;
	logic [fcpa_pkg::LIVE_OUT_W-1:0] live_total;

	modport source (output valid, result_address, status, used_total, live_total, input ready);
	modport sink   (input valid, result_address, status, used_total, live_total, output ready);
endinterface

// File: rtl/core/fixed_chunk_pool_allocator.sv
// Fixed chunk pool allocator: top level with the free-list stack controller.
// Depends on fcpa_pkg, fcpa_if (fcpa_cmd_if, fcpa_res_if) and fcpa_ram.
//
// Usage:
//   Configuration is written through cfg_we/cfg_index/cfg_data while the block is
//   idle; it takes effect at the next clear command, but the free range check
//   uses the pool base register at once. Each command beat on cmd (allocate, free,
//   clear) yields exactly one result beat on res, which carries the allocated
//   address, a status code and the byte and chunk counts after the command.
//   The free list lives in a RAM with a registered read, and one command is in
//   flight at a time. Free, unused modes and an allocate on an empty pool load the
//   result register at the accept edge; a successful allocate waits in S_POP for
//   the RAM read, which S_POP then loads into the result register.
//   Clear lays out the pool in S_CLR0 and S_CLR1, then pushes one chunk address
//   per cycle into the RAM in S_FILL and loads the result once no whole chunk
//   remains; at most MAX_CHUNKS chunks are pushed. A bad configuration ends in
//   S_CLR1.
//   A new command is taken when the result register is empty or its beat is being
//   taken in the same cycle; a stalled receiver holds the result and the block.
//   After reset the pool is empty (every allocate reports empty until a clear);
//   registers hold base 0, size 0, chunk size 8 and alignment log2 3. The RAM
//   needs no clearing pass: only entries already pushed are ever popped.
module fixed_chunk_pool_allocator #(
	parameter int MAX_CHUNKS = 256,
	parameter int ADDR_WIDTH = 32,
	parameter int MIN_CHUNK  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fcpa_pkg::DATA_W-1:0]       cfg_data,
	fcpa_cmd_if.sink                          cmd,
	fcpa_res_if.source                        res
);

	import fcpa_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_CHUNKS + 1);
	localparam int IDX_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int ADDR_X  = DATA_W + 1;

	// Controller states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POP  = 3'd1;
	localparam logic [2:0] S_CLR0 = 3'd2;
	localparam logic [2:0] S_CLR1 = 3'd3;
	localparam logic [2:0] S_FILL = 3'd4;

	logic [2:0]            state_q;

	// Configuration registers.
	logic [DATA_W-1:0]     pool_base_q;
	logic [DATA_W-1:0]     pool_bytes_q;
	logic [CHUNK_W-1:0]    chunk_bytes_q;
	logic [ALIGN_W-1:0]    align_log2_q;

	// Pool state.
	logic [DEPTH_W-1:0]    depth_q;
	logic [DATA_W-1:0]     bytes_q;
	logic [DEPTH_W-1:0]    live_q;
	logic [DEPTH_W-1:0]    total_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [ADDR_X-1:0]     last_q;

	// Clear layout and fill sequencer.
	logic [ADDR_X-1:0]     aligned_q;
	logic [PAD_W-1:0]      pad_q;
	logic [STRIDE_W-1:0]   stride_new_q;
	logic [DATA_W-1:0]     remain_q;
	logic [ADDR_X-1:0]     cur_q;
	logic [DEPTH_W-1:0]    fill_cnt_q;

	// Result register.
	logic                  res_valid_q;
	logic [DATA_W-1:0]     res_addr_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [DATA_W-1:0]     res_used_q;
	logic [LIVE_OUT_W-1:0] res_live_q;

	// RAM ports.
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [DATA_W-1:0]     ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [DATA_W-1:0]     ram_rdata;

	logic                  accept;
	logic                  pop_ok;
	logic                  in_range;
	logic                  stack_full;
	logic                  free_ok;
	logic [STATUS_W-1:0]   free_status;
	logic [DATA_W-1:0]     stride_ext;
	logic [DATA_W-1:0]     bytes_dec;
	logic [DEPTH_W-1:0]    live_dec;
	logic                  fill_go;
	logic [PAD_W-1:0]      align_m1;
	logic [ADDR_X-1:0]     aligned_c;
	logic [STRIDE_W-1:0]   stride_c;
	logic [ADDR_X-1:0]     pool_end;
	logic                  addr_over;
	logic [DATA_W-1:0]     remain_c;
	logic                  bad_cfg;

	assign res.valid          = res_valid_q;
	assign res.result_address = res_addr_q;
	assign res.status         = res_status_q;
	assign res.used_total     = res_used_q;
	assign res.live_total     = res_live_q;

	// A command is taken only in idle, with the result register free by the same edge.
	assign cmd.ready = (state_q == S_IDLE) && (!res_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	// Allocate and free checks.
	assign pop_ok     = (depth_q != '0);
	assign in_range   = (total_q != '0) && (cmd.address >= pool_base_q)
	                    && ({1'b0, cmd.address} <= last_q);
	assign stack_full = (depth_q >= DEPTH_W'(MAX_CHUNKS));
	assign stride_ext = DATA_W'(stride_q);
	assign bytes_dec  = (bytes_q >= stride_ext) ? (bytes_q - stride_ext) : '0;
	assign live_dec   = (live_q != '0) ? (live_q - 1'b1) : '0;

	always_comb begin
		if (cmd.address == '0) begin
			free_status = ST_NULL;
		end else if (!in_range) begin
			free_status = ST_RANGE;
		end else if (stack_full) begin
			free_status = ST_OVERFLOW;
		end else begin
			free_status = ST_OK;
		end
	end
	assign free_ok = (free_status == ST_OK);

	// Clear layout: base rounded up to the alignment, stride rounded up to a multiple.
	assign align_m1  = PAD_W'((9'd1 << align_log2_q) - 9'd1);
	assign aligned_c = ({1'b0, pool_base_q} + ADDR_X'(align_m1)) & ~ADDR_X'(align_m1);
	assign stride_c  = (STRIDE_W'(chunk_bytes_q) + STRIDE_W'(align_m1))
	                   & ~STRIDE_W'(align_m1);

	// Clear checks, taken in S_CLR1 from the layout registers.
	assign pool_end  = {1'b0, pool_base_q} + {1'b0, pool_bytes_q} - ADDR_X'(1);
	assign addr_over = (ADDR_WIDTH < ADDR_X) && ((pool_end >> ADDR_WIDTH) != '0);
	assign remain_c  = pool_bytes_q - DATA_W'(pad_q);
	assign bad_cfg   = (DATA_W'(pad_q) > pool_bytes_q)
	                   || ((pool_bytes_q != '0) && addr_over)
	                   || (stride_new_q < STRIDE_W'(MIN_CHUNK))
	                   || (remain_c < DATA_W'(stride_new_q));

	// Fill keeps pushing while a whole chunk remains and the stack has room.
	assign fill_go = (remain_q >= DATA_W'(stride_new_q))
	                 && (fill_cnt_q != DEPTH_W'(MAX_CHUNKS));

	// RAM access: pushes from free and fill, pop read at the allocate accept.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(depth_q);
		ram_wdata = cmd.address;
		if (state_q == S_FILL) begin
			ram_we    = fill_go;
			ram_waddr = IDX_W'(fill_cnt_q);
			ram_wdata = cur_q[DATA_W-1:0];
		end else if (accept && (cmd.mode == MODE_FREE)) begin
			ram_we = free_ok;
		end
	end
	assign ram_re    = accept && (cmd.mode == MODE_ALLOC) && pop_ok;
	assign ram_raddr = IDX_W'(depth_q - 1'b1);

	fcpa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_CHUNKS)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			pool_bytes_q  <= '0;
			chunk_bytes_q <= CHUNK_W'(8);
			align_log2_q  <= ALIGN_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BASE:   pool_base_q   <= cfg_data;
				REG_POOL_BYTES:  pool_bytes_q  <= cfg_data;
				REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[CHUNK_W-1:0];
				REG_ALIGN_LOG2:  align_log2_q  <= cfg_data[ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller, pool counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_valid_q  <= 1'b0;
			depth_q      <= '0;
			bytes_q      <= '0;
			live_q       <= '0;
			total_q      <= '0;
			stride_q     <= '0;
			last_q       <= '0;
			fill_cnt_q   <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_used_q   <= '0;
			res_live_q   <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.mode)
							MODE_ALLOC: begin
								if (pop_ok) begin
									depth_q <= depth_q - 1'b1;
									bytes_q <= bytes_q + stride_ext;
									live_q  <= live_q + 1'b1;
									state_q <= S_POP;
								end else begin
									res_valid_q  <= 1'b1;
									res_addr_q   <= '0;
									res_status_q <= ST_EMPTY;
									res_used_q   <= bytes_q;
									res_live_q   <= LIVE_OUT_W'(live_q);
								end
							end
							MODE_FREE: begin
								res_valid_q  <= 1'b1;
								res_addr_q   <= '0;
								res_status_q <= free_status;
								if (free_ok) begin
									depth_q    <= depth_q + 1'b1;
									bytes_q    <= bytes_dec;
									live_q     <= live_dec;
									res_used_q <= bytes_dec;
									res_live_q <= LIVE_OUT_W'(live_dec);
								end else begin
									res_used_q <= bytes_q;
									res_live_q <= LIVE_OUT_W'(live_q);
								end
							end
							MODE_CLEAR: begin
								// The old pool is dropped before the new one is laid out.
								depth_q  <= '0;
								bytes_q  <= '0;
								live_q   <= '0;
								total_q  <= '0;
								stride_q <= '0;
								last_q   <= '0;
								state_q  <= S_CLR0;
							end
							default: begin
								res_valid_q  <= 1'b1;
								res_addr_q   <= '0;
								res_status_q <= ST_OK;
								res_used_q   <= bytes_q;
								res_live_q   <= LIVE_OUT_W'(live_q);
							end
						endcase
					end
				end
				S_POP: begin
					res_valid_q  <= 1'b1;
					res_addr_q   <= ram_rdata;
					res_status_q <= ST_OK;
					res_used_q   <= bytes_q;
					res_live_q   <= LIVE_OUT_W'(live_q);
					state_q      <= S_IDLE;
				end
				S_CLR0: begin
					state_q <= S_CLR1;
				end
				S_CLR1: begin
					fill_cnt_q <= '0;
					if (bad_cfg) begin
						res_valid_q  <= 1'b1;
						res_addr_q   <= '0;
						res_status_q <= ST_BADCFG;
						res_used_q   <= '0;
						res_live_q   <= '0;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_go) begin
						last_q     <= cur_q;
						fill_cnt_q <= fill_cnt_q + 1'b1;
					end else begin
						depth_q      <= fill_cnt_q;
						total_q      <= fill_cnt_q;
						stride_q     <= stride_new_q;
						res_valid_q  <= 1'b1;
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						res_used_q   <= '0;
						res_live_q   <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Layout and fill datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_CLR0) begin
			aligned_q    <= aligned_c;
			pad_q        <= PAD_W'(aligned_c - {1'b0, pool_base_q});
			stride_new_q <= stride_c;
		end
		if (state_q == S_CLR1) begin
			remain_q <= remain_c;
			// Chunk addresses start from the aligned base truncated to the address field.
			cur_q    <= {1'b0, aligned_q[DATA_W-1:0]};
		end
		if ((state_q == S_FILL) && fill_go) begin
			remain_q <= remain_q - DATA_W'(stride_new_q);
			cur_q    <= cur_q + ADDR_X'(stride_new_q);
		end
	end

endmodule

// File: rtl/core/fcpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fcpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fcpa_chk.sv
// Port-level checker for the fixed chunk pool allocator, bound to the top level.
// Depends on fcpa_pkg and fixed_chunk_pool_allocator.
module fcpa_chk #(
	parameter int MAX_CHUNKS = 256
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [fcpa_pkg::DATA_W-1:0]       res_result_address,
	input logic [fcpa_pkg::STATUS_W-1:0]     res_status,
	input logic [fcpa_pkg::DATA_W-1:0]       res_used_total,
	input logic [fcpa_pkg::LIVE_OUT_W-1:0]   res_live_total
);

	import fcpa_pkg::*;

	// A result beat stays offered until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before it was taken");

	// A stalled result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_result_address) && $stable(res_status)
		&& $stable(res_used_total) && $stable(res_live_total))
		else $error("result payload changed while stalled");

	// Only a successful allocate carries an address.
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status != ST_OK) |-> res_result_address == '0)
		else $error("failed command returned an address");

	// A rejected clear reports an empty pool.
	a_badcfg_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_BADCFG) |-> (res_used_total == '0)
		&& (res_live_total == '0))
		else $error("bad configuration left counts behind");

	// The live count never exceeds the pool capacity.
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_live_total) <= 32'(MAX_CHUNKS))
		else $error("live chunk count beyond capacity");

endmodule

bind fixed_chunk_pool_allocator fcpa_chk #(
	.MAX_CHUNKS (MAX_CHUNKS)
) u_fcpa_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_result_address (res.result_address),
	.res_status         (res.status),
	.res_used_total     (res.used_total),
	.res_live_total     (res.live_total)
);

// File: tb/sv/tb_fixed_chunk_pool_allocator.sv
// Testbench for fixed_chunk_pool_allocator: a directed table, then random phases of allocate,
// free and clear beats, each result beat checked against an in-bench free-list predictor.
// Depends on fcpa_pkg, the fcpa_cmd_if/fcpa_res_if interfaces and the allocator RTL.
module tb_fixed_chunk_pool_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import fcpa_pkg::*;

	localparam int POOL_SLOTS   = 256;
	localparam int STRIDE_FLOOR = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 150;
	localparam logic [63:0] ADDR_SPACE_TOP = 64'h0000_0000_FFFF_FFFF;
	// The fourth mode code has no operation behind it.
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0]     addr;
		logic [STATUS_W-1:0]   status;
		logic [DATA_W-1:0]     used;
		logic [LIVE_OUT_W-1:0] live;
	} outcome_t;

	typedef enum logic {ROW_CONFIG, ROW_COMMAND} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [MODE_W-1:0]        mode;
		logic [DATA_W-1:0]        address;
		logic [3:0][DATA_W-1:0]   cfg_words;
		logic                     typed;
		outcome_t                 want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	fcpa_cmd_if cmd_ch ();
	fcpa_res_if res_ch ();

	fixed_chunk_pool_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// Predictor copy of the registers and of the free list.
	logic [DATA_W-1:0]  base_reg;
	logic [DATA_W-1:0]  size_reg;
	logic [CHUNK_W-1:0] chunk_reg;
	logic [ALIGN_W-1:0] align_reg;
	logic [DATA_W-1:0]  free_stack [POOL_SLOTS];
	int                 stack_fill;
	int                 chunks_live;
	int                 chunk_count;
	logic [DATA_W-1:0]  bytes_used;
	logic [DATA_W-1:0]  stride_bytes;
	logic [DATA_W-1:0]  first_addr;

	outcome_t          pending_outcomes [$];
	logic [DATA_W-1:0] held_chunks [$];
	stim_row_t         directed_rows [$];
	outcome_t          oldest;
	int                err_count = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one command to the predictor state and returns the result beat it should cause.
	function automatic outcome_t pool_op_outcome(input logic [MODE_W-1:0] mode,
			input logic [DATA_W-1:0] address);
		outcome_t o;
		logic [63:0] align, aligned, pad, stride, remain, n, last;
		int i;
		o = '0;
		o.status = ST_OK;
		case (mode)
			MODE_ALLOC: begin
				if (stack_fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					stack_fill--;
					o.addr = free_stack[stack_fill];
					bytes_used += stride_bytes;
					chunks_live++;
				end
			end
			MODE_FREE: begin
				last = (chunk_count == 0) ? 64'd0 :
					64'(first_addr) + 64'(chunk_count - 1) * 64'(stride_bytes);
				if (address == '0) begin
					o.status = ST_NULL;
				end else if (chunk_count == 0 || address < base_reg || 64'(address) > last) begin
					o.status = ST_RANGE;
				end else if (stack_fill >= POOL_SLOTS) begin
					o.status = ST_OVERFLOW;
				end else begin
					free_stack[stack_fill] = address;
					stack_fill++;
					bytes_used = (bytes_used >= stride_bytes) ? bytes_used - stride_bytes : '0;
					if (chunks_live > 0)
						chunks_live--;
				end
			end
			MODE_CLEAR: begin
				// Lay out the pool from scratch; a bad layout leaves it empty.
				align = 64'd1 << align_reg;
				aligned = (64'(base_reg) + align - 1) & ~(align - 1);
				pad = aligned - 64'(base_reg);
				stride = (64'(chunk_reg) + align - 1) & ~(align - 1);
				stack_fill = 0;
				bytes_used = '0;
				chunks_live = 0;
				chunk_count = 0;
				stride_bytes = '0;
				first_addr = '0;
				remain = 64'(size_reg) - pad;
				if (pad > 64'(size_reg)
						|| (size_reg != '0 && 64'(base_reg) + 64'(size_reg) - 1 > ADDR_SPACE_TOP)
						|| stride < STRIDE_FLOOR || remain < stride) begin
					o.status = ST_BADCFG;
				end else begin
					n = remain / stride;
					if (n > POOL_SLOTS)
						n = POOL_SLOTS;
					for (i = 0; i < n; i++)
						free_stack[i] = DATA_W'(aligned + i * stride);
					stack_fill = int'(n);
					chunk_count = int'(n);
					stride_bytes = DATA_W'(stride);
					first_addr = DATA_W'(aligned);
				end
			end
			default: begin
			end
		endcase
		o.used = bytes_used;
		o.live = LIVE_OUT_W'(chunks_live);
		return o;
	endfunction

	function automatic stim_row_t cfg_row(input logic [DATA_W-1:0] base,
			input logic [DATA_W-1:0] size, input logic [DATA_W-1:0] chunk,
			input logic [DATA_W-1:0] align);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CONFIG;
		r.cfg_words[0] = base;
		r.cfg_words[1] = size;
		r.cfg_words[2] = chunk;
		r.cfg_words[3] = align;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [MODE_W-1:0] mode,
			input logic [DATA_W-1:0] address, input logic [STATUS_W-1:0] status,
			input logic [DATA_W-1:0] addr_out, input logic [DATA_W-1:0] used,
			input logic [LIVE_OUT_W-1:0] live);
		stim_row_t r;
		r = '0;
		r.kind = ROW_COMMAND;
		r.mode = mode;
		r.address = address;
		r.typed = 1'b1;
		r.want.addr = addr_out;
		r.want.status = status;
		r.want.used = used;
		r.want.live = live;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Drives one command beat, waits for it to be taken and records what it should return.
	// Called at a rising edge; valid stays high when the next beat follows at once.
	task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] address,
			input logic typed, input outcome_t want);
		outcome_t predicted;
		if ($urandom_range(99, 0) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.address <= address;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = pool_op_outcome(mode, address);
		pending_outcomes.push_back(typed ? want : predicted);
		if (mode == MODE_CLEAR)
			held_chunks.delete();
		else if (mode == MODE_ALLOC && predicted.status == ST_OK)
			held_chunks.push_back(predicted.addr);
	endtask

	// Drops valid and holds off until every expected result beat has arrived.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Writes all four registers on consecutive edges; the block must be idle.
	task automatic write_config(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] size,
			input logic [DATA_W-1:0] chunk, input logic [DATA_W-1:0] align);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [DATA_W-1:0] word [4];
		int i;
		idx = '{REG_POOL_BASE, REG_POOL_BYTES, REG_CHUNK_BYTES, REG_ALIGN_LOG2};
		word = '{base, size, chunk, align};
		for (i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= word[i];
			@(posedge clk);
			case (idx[i])
				REG_POOL_BASE: base_reg = word[i];
				REG_POOL_BYTES: size_reg = word[i];
				REG_CHUNK_BYTES: chunk_reg = word[i][CHUNK_W-1:0];
				REG_ALIGN_LOG2: align_reg = word[i][ALIGN_W-1:0];
				default: begin
				end
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Mostly a well-formed pool of 1 to 24 chunks; some phases a full pool or raw values.
	task automatic pick_config(input int phase);
		logic [DATA_W-1:0] base, size, chunk;
		logic [ALIGN_W-1:0] align;
		logic [63:0] step, aligned, slack;
		int count;
		align = ALIGN_W'($urandom_range(7, 0));
		chunk = ($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(200, 8);
		count = (phase % 4 == 2) ? 300 : $urandom_range(24, 1);
		step = (64'(chunk) + (64'd1 << align) - 1) & ~((64'd1 << align) - 1);
		base = $urandom_range(32'hE000_0000, 0);
		aligned = (64'(base) + (64'd1 << align) - 1) & ~((64'd1 << align) - 1);
		slack = (step == 0) ? 64'd0 : 64'($urandom_range(DATA_W'(step - 1), 0));
		size = DATA_W'(aligned - 64'(base) + count * step + slack);
		if (phase == 5) begin
			base = $urandom;
			size = $urandom;
		end
		write_config(base, size, {16'($urandom), chunk[CHUNK_W-1:0]}, {29'($urandom), align});
	endtask

	// One random command: mostly allocates and frees of chunks handed out earlier,
	// the rest range edges, double frees, null and raw addresses, no-ops and clears.
	task automatic send_random_op();
		int pick, k;
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] address;
		pick = $urandom_range(99, 0);
		address = $urandom;
		mode = MODE_ALLOC;
		if (pick < 45) begin
			mode = MODE_ALLOC;
		end else if (pick < 80) begin
			if (held_chunks.size() > 0) begin
				mode = MODE_FREE;
				k = $urandom_range(held_chunks.size() - 1, 0);
				address = held_chunks[k];
				held_chunks.delete(k);
			end
		end else if (pick < 87) begin
			// Points on the chunk grid, one past the end, and one off either side.
			mode = MODE_FREE;
			address = first_addr + stride_bytes * DATA_W'($urandom_range(chunk_count, 0));
			case ($urandom_range(3, 0))
				0: address = address - 1;
				1: address = address + 1;
				default: begin
				end
			endcase
		end else if (pick < 91) begin
			mode = MODE_FREE;
		end else if (pick < 93) begin
			mode = MODE_FREE;
			address = '0;
		end else if (pick < 96) begin
			mode = MODE_NOP;
		end else begin
			mode = MODE_CLEAR;
		end
		send_cmd(mode, address, 1'b0, '0);
	endtask

	// Result side: check each accepted beat, then choose ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got addr %h status %0d",
					$time, res_ch.result_address, res_ch.status);
				err_count++;
			end else begin
				oldest = pending_outcomes.pop_front();
				check_field("result_address", oldest.addr, res_ch.result_address);
				check_field("status", DATA_W'(oldest.status), DATA_W'(res_ch.status));
				check_field("used_total", oldest.used, res_ch.used_total);
				check_field("live_total", DATA_W'(oldest.live), DATA_W'(res_ch.live_total));
			end
		end
		res_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int k, phase, beat;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = '0;
		cmd_ch.address = '0;
		res_ch.ready = 1'b0;
		base_reg = '0;
		size_reg = '0;
		chunk_reg = CHUNK_W'(8);
		align_reg = ALIGN_W'(3);
		stack_fill = 0;
		chunks_live = 0;
		chunk_count = 0;
		bytes_used = '0;
		stride_bytes = '0;
		first_addr = '0;

		// Directed rows. Config rows never follow one another directly.
		// Empty pool out of reset with the reset register values.
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_EMPTY, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h0, ST_NULL, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h0000_0100, ST_RANGE, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_NOP, 32'hFFFF_FFFF, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_BADCFG, 0, 0, 0));
		// Unaligned base, chunk size rounded up: seven chunks from 0x1008 to 0x1038.
		directed_rows.push_back(cfg_row(32'h0000_1003, 32'h40, 32'd5, 32'd3));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'hFFFF_FFFF, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_OK, 32'h1038, 8, 1));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_OK, 32'h1030, 16, 2));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h1038, ST_OK, 0, 8, 1));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h1003, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h1039, ST_RANGE, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h1002, ST_RANGE, 0, 0, 0));
		// Free with both counts at zero: the counts stay at zero.
		directed_rows.push_back(typed_row(MODE_FREE, 32'h1010, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_OK, 32'h1010, 8, 1));
		directed_rows.push_back(typed_row(MODE_FREE, 32'hFFFF_FFFF, ST_RANGE, 0, 8, 1));
		// Largest pool and chunk size: the stack is full right after the clear.
		directed_rows.push_back(cfg_row(32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd3));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h10, ST_OVERFLOW, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_OK, 32'h00FF_0000,
			32'h0001_0000, 1));
		// Pool running past the top of the address space.
		directed_rows.push_back(cfg_row(32'hFFFF_FF00, 32'h101, 32'd8, 32'd3));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_BADCFG, 0, 0, 0));
		// Alignment pad larger than the pool, zero chunk size.
		directed_rows.push_back(cfg_row(32'h81, 32'h20, 32'd0, 32'd7));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_BADCFG, 0, 0, 0));
		// Stride below the minimum chunk.
		directed_rows.push_back(cfg_row(32'h1000, 32'h100, 32'd1, 32'd0));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_BADCFG, 0, 0, 0));
		// Exactly one chunk at the widest alignment.
		directed_rows.push_back(cfg_row(32'h8000_0000, 32'h80, 32'h80, 32'd7));
		directed_rows.push_back(typed_row(MODE_CLEAR, 32'h0, ST_OK, 0, 0, 0));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_OK, 32'h8000_0000, 128, 1));
		directed_rows.push_back(typed_row(MODE_ALLOC, 32'h0, ST_EMPTY, 0, 128, 1));
		directed_rows.push_back(typed_row(MODE_FREE, 32'h8000_0000, ST_OK, 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < directed_rows.size(); k++) begin
			if (directed_rows[k].kind == ROW_CONFIG) begin
				wait_idle();
				write_config(directed_rows[k].cfg_words[0], directed_rows[k].cfg_words[1],
					directed_rows[k].cfg_words[2], directed_rows[k].cfg_words[3]);
			end else begin
				send_cmd(directed_rows[k].mode, directed_rows[k].address,
					directed_rows[k].typed, directed_rows[k].want);
			end
		end

		// Random phases, each with its own configuration and idle pattern.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 46; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 46; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			pick_config(phase);
			send_cmd(MODE_CLEAR, $urandom, 1'b0, '0);
			for (beat = 0; beat < PHASE_BEATS; beat++) begin
				// Halfway through, let the block drain completely.
				if (beat == PHASE_BEATS / 2)
					wait_idle();
				send_random_op();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
